[hw/rtl/aoc_pkg.sv]
// Shared types and constants for the ADC offset calibrator.
// Used by aoc_div and adc_offset_calibrator_core; depends on nothing.
package aoc_pkg;

  // Configuration register width and reset values
  localparam int unsigned CfgW          = 16;
  localparam int unsigned SampleBitsDef = 12;
  localparam logic [CfgW-1:0] WaitMsRst = 16'd300;
  localparam logic [CfgW-1:0] SettleRst = 16'd4000;
  localparam logic [CfgW-1:0] CaliRst   = 16'd4000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgWaitMs = 2'd0,
    CfgSettle = 2'd1,
    CfgCali   = 2'd2
  } cfg_idx_e;

  // Request opcodes
  typedef enum logic {
    OpSample = 1'b0,
    OpTick   = 1'b1
  } op_e;

  // Control sequencer states
  typedef enum logic [3:0] {
    StIdle     = 4'b0001,
    StDivStart = 4'b0010,
    StDiv      = 4'b0100,
    StResult   = 4'b1000
  } state_e;

  // Status of a serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hw/rtl/aoc_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on aoc_pkg; instantiated by adc_offset_calibrator_core.
module aoc_div #(
  parameter int unsigned SAMPLE_BITS = aoc_pkg::SampleBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [SAMPLE_BITS+aoc_pkg::CfgW-1:0]  dividend_i,
  input  logic [aoc_pkg::CfgW-1:0]              divisor_i,
  output logic [SAMPLE_BITS-1:0]                quotient_o,
  output aoc_pkg::div_stat_t                    stat_o
);
  import aoc_pkg::*;

  localparam int unsigned SumW = SAMPLE_BITS + CfgW;
  localparam int unsigned CntW = $clog2(SAMPLE_BITS + 1);

  logic [CfgW-1:0]        rem_q, rem_d;
  logic [CfgW-1:0]        dvs_q, dvs_d;
  logic [SAMPLE_BITS-1:0] quo_q, quo_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CfgW:0]          trial;
  logic [CfgW:0]          diff;
  logic                   take;

  // Partial remainder with the next dividend bit shifted in
  assign trial = {rem_q, quo_q[SAMPLE_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = (trial >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // The quotient fits SAMPLE_BITS, so the upper dividend part is below the divisor
      rem_d  = dividend_i[SumW-1:SAMPLE_BITS];
      quo_d  = dividend_i[SAMPLE_BITS-1:0];
      dvs_d  = divisor_i;
      cnt_d  = CntW'(SAMPLE_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? diff[CfgW-1:0] : trial[CfgW-1:0];
      quo_d = {quo_q[SAMPLE_BITS-2:0], take};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

[hw/rtl/adc_offset_calibrator_core.sv]
// Top level of the ADC zero-offset calibrator: control, accumulators, outputs.
// Depends on aoc_pkg and instantiates two aoc_div units (phase A and phase B).
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request per accepted edge:
//   op_i = OpTick counts one millisecond, op_i = OpSample delivers a raw pair
//   raw_a_i/raw_b_i. Every request yields exactly one result on the output
//   channel (out_valid_o/out_ready_i): calibrated flag, both offsets and the
//   signed deltas of the most recent raw pair against the current offsets.
//   Configuration channel (cfg_valid_i/cfg_ready_o) writes the tick wait, the
//   number of discarded pairs and the number of averaged pairs by index; it is
//   always ready. Write it only while idle.
// Sequencing:
//   An ordinary request is accepted, then loaded into the output register.
//   The sample that completes calibration passes StDivStart and StDiv first,
//   where the bit-serial dividers produce one offset bit per cycle.
//   The output register decouples the channels: a new request is accepted while
//   the previous result still waits; a stalled receiver holds the sequencer in
//   its result state until the output register frees up.
// Reset: offsets go to mid-scale, counters and sums clear, registers take their
//   default values; no clearing pass is needed.
module adc_offset_calibrator_core #(
  parameter int unsigned SAMPLE_BITS = aoc_pkg::SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [aoc_pkg::CfgW-1:0]     cfg_data_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [SAMPLE_BITS-1:0]       raw_a_i,
  input  logic [SAMPLE_BITS-1:0]       raw_b_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         calibrated_o,
  output logic [SAMPLE_BITS-1:0]       offset_a_o,
  output logic [SAMPLE_BITS-1:0]       offset_b_o,
  output logic signed [SAMPLE_BITS:0]  delta_a_o,
  output logic signed [SAMPLE_BITS:0]  delta_b_o
);
  import aoc_pkg::*;

  localparam int unsigned SumW = SAMPLE_BITS + CfgW;
  localparam logic [SAMPLE_BITS-1:0] MidCode = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration registers
  logic [CfgW-1:0] wait_ms_q, wait_ms_d;
  logic [CfgW-1:0] settle_cfg_q, settle_cfg_d;
  logic [CfgW-1:0] cali_cfg_q, cali_cfg_d;

  // Calibration state
  state_e                 state_q, state_d;
  logic [CfgW-1:0]        elapsed_q, elapsed_d;
  logic [CfgW-1:0]        settle_cnt_q, settle_cnt_d;
  logic [CfgW-1:0]        sample_cnt_q, sample_cnt_d;
  logic [SumW-1:0]        sum_a_q, sum_a_d;
  logic [SumW-1:0]        sum_b_q, sum_b_d;
  logic [SAMPLE_BITS-1:0] offset_a_q, offset_a_d;
  logic [SAMPLE_BITS-1:0] offset_b_q, offset_b_d;
  logic                   cal_done_q, cal_done_d;
  logic [SAMPLE_BITS-1:0] last_a_q, last_a_d;
  logic [SAMPLE_BITS-1:0] last_b_q, last_b_d;

  // Output register
  logic                   out_valid_q, out_valid_d;
  logic                   out_cal_q;
  logic [SAMPLE_BITS-1:0] out_off_a_q, out_off_b_q;
  logic [SAMPLE_BITS:0]   out_dlt_a_q, out_dlt_b_q;

  logic                   in_fire;
  logic                   out_load;
  logic [CfgW-1:0]        cnt_inc;
  logic                   div_start;
  logic [SAMPLE_BITS-1:0] quo_a, quo_b;
  div_stat_t              div_a_stat, div_b_stat;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cnt_inc     = sample_cnt_q + CfgW'(1);
  assign div_start   = (state_q == StDivStart);
  // Load the result once the output register is free or being drained
  assign out_load    = (state_q == StResult) && (!out_valid_q || out_ready_i);

  // Register writes
  always_comb begin
    wait_ms_d    = wait_ms_q;
    settle_cfg_d = settle_cfg_q;
    cali_cfg_d   = cali_cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgWaitMs: wait_ms_d    = cfg_data_i;
        CfgSettle: settle_cfg_d = cfg_data_i;
        CfgCali:   cali_cfg_d   = cfg_data_i;
        default:   ; // drop writes beyond the register list
      endcase
    end
  end

  // Request processing and sequencing
  always_comb begin
    state_d      = state_q;
    elapsed_d    = elapsed_q;
    settle_cnt_d = settle_cnt_q;
    sample_cnt_d = sample_cnt_q;
    sum_a_d      = sum_a_q;
    sum_b_d      = sum_b_q;
    offset_a_d   = offset_a_q;
    offset_b_d   = offset_b_q;
    cal_done_d   = cal_done_q;
    last_a_d     = last_a_q;
    last_b_d     = last_b_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StResult;
          if (op_e'(op_i) == OpTick) begin
            // Saturate at the wait limit
            if (elapsed_q < wait_ms_q) begin
              elapsed_d = elapsed_q + CfgW'(1);
            end
          end else begin
            last_a_d = raw_a_i;
            last_b_d = raw_b_i;
            if (!cal_done_q && (elapsed_q >= wait_ms_q)) begin
              if (settle_cnt_q < settle_cfg_q) begin
                settle_cnt_d = settle_cnt_q + CfgW'(1);
              end else begin
                sum_a_d      = sum_a_q + SumW'(raw_a_i);
                sum_b_d      = sum_b_q + SumW'(raw_b_i);
                sample_cnt_d = cnt_inc;
                if ((cnt_inc >= cali_cfg_q) && (cnt_inc != '0)) begin
                  cal_done_d = 1'b1;
                  state_d    = StDivStart;
                end
              end
            end
          end
        end
      end
      StDivStart: begin
        state_d = StDiv;
      end
      StDiv: begin
        // Both dividers run in lockstep; commit the frozen offsets
        if (div_a_stat.done) begin
          offset_a_d = quo_a;
          offset_b_d = quo_b;
          state_d    = StResult;
        end
      end
      StResult: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_ms_q    <= WaitMsRst;
      settle_cfg_q <= SettleRst;
      cali_cfg_q   <= CaliRst;
      state_q      <= StIdle;
      elapsed_q    <= '0;
      settle_cnt_q <= '0;
      sample_cnt_q <= '0;
      sum_a_q      <= '0;
      sum_b_q      <= '0;
      offset_a_q   <= MidCode;
      offset_b_q   <= MidCode;
      cal_done_q   <= 1'b0;
      last_a_q     <= '0;
      last_b_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      wait_ms_q    <= wait_ms_d;
      settle_cfg_q <= settle_cfg_d;
      cali_cfg_q   <= cali_cfg_d;
      state_q      <= state_d;
      elapsed_q    <= elapsed_d;
      settle_cnt_q <= settle_cnt_d;
      sample_cnt_q <= sample_cnt_d;
      sum_a_q      <= sum_a_d;
      sum_b_q      <= sum_b_d;
      offset_a_q   <= offset_a_d;
      offset_b_q   <= offset_b_d;
      cal_done_q   <= cal_done_d;
      last_a_q     <= last_a_d;
      last_b_q     <= last_b_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload: hold while stalled, advance on load
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cal_q   <= cal_done_q;
      out_off_a_q <= offset_a_q;
      out_off_b_q <= offset_b_q;
      out_dlt_a_q <= {1'b0, last_a_q} - {1'b0, offset_a_q};
      out_dlt_b_q <= {1'b0, last_b_q} - {1'b0, offset_b_q};
    end
  end

  aoc_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_a_q),
    .divisor_i (sample_cnt_q),
    .quotient_o(quo_a),
    .stat_o    (div_a_stat)
  );

  aoc_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_b_q),
    .divisor_i (sample_cnt_q),
    .quotient_o(quo_b),
    .stat_o    (div_b_stat)
  );

  assign out_valid_o  = out_valid_q;
  assign calibrated_o = out_cal_q;
  assign offset_a_o   = out_off_a_q;
  assign offset_b_o   = out_off_b_q;
  assign delta_a_o    = out_dlt_a_q;
  assign delta_b_o    = out_dlt_b_q;

`ifndef SYNTH
  // Calibration never reverts
  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_done_q |=> cal_done_q)
    else $error("calibrated flag dropped");

  // Offsets change only when a division commits
  a_offsets_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StDiv) |=> ($stable(offset_a_q) && $stable(offset_b_q)))
    else $error("offset changed outside division commit");

  // Both dividers stay in lockstep
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_a_stat == div_b_stat))
    else $error("phase dividers out of step");

  // No request is taken while a division is running
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_a_stat.busy || div_a_stat.done) |-> (!in_ready_o && (state_q == StDiv)))
    else $error("request accepted during division");
`endif

endmodule
